[rtl/core/bitmap_page_allocator_unit_macros.svh]
// assertion macros for the bitmap page allocator
`ifndef BITMAP_PAGE_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_UNIT_MACROS_SVH

// condition that holds at every clock edge out of reset
`define BPA_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence that holds in the cycle after the antecedent
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/bpa_pkg.sv]
// package for the bitmap page allocator: sizes, opcodes and transfer types
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

  localparam int NUM_BYTES     = 128;
  localparam int BITS_PER_BYTE = 8;
  localparam int NUM_SLOTS     = NUM_BYTES * BITS_PER_BYTE;
  localparam int BYTE_AW       = (NUM_BYTES > 1) ? $clog2(NUM_BYTES) : 1;
  localparam int CNT_W         = $clog2(NUM_SLOTS + 1);

  localparam logic [7:0] FULL_BYTE = 8'hFF;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [9:0] slot_index;
  } bpa_req_t;

  typedef struct packed {
    logic        success;
    logic [9:0]  granted_slot;
    logic [10:0] used_count;
  } bpa_rsp_t;

endpackage

`default_nettype wire

[rtl/core/bitmap_page_allocator_unit.sv]
// Bitmap page allocator: one request per transfer, one response per request.
// The bitmap holds one bit per slot in a byte-wide memory with one read and one
// write port; a per-byte valid flag cleared by reset makes the whole bitmap free
// at once, so no clearing pass is needed. Allocate reads bytes from the lowest
// upward, one per cycle, and stops at the first byte that is not full; when the
// bitmap is full it fails after the last byte. Free and query read one byte.
// A response that still waits on out_stall holds the next one back until it is
// taken. in_stall is high from request transfer until the response has been placed
// in the output register; a response that waits on out_stall does not block the
// next request from being taken.
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_page_allocator_unit_macros.svh"

module bitmap_page_allocator_unit
  import bpa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire bpa_req_t in_req,
  output logic          out_valid,
  input  wire logic     out_stall,
  output bpa_rsp_t      out_rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SLOT,
    S_DONE
  } state_t;

  // bitmap memory and per-byte valid flags
  logic [7:0]         usage_mem [NUM_BYTES];
  logic [NUM_BYTES-1:0] byte_vld_r;

  state_t             state_r, state_nxt;
  logic [1:0]         op_r, op_nxt;
  logic [9:0]         slot_r, slot_nxt;
  logic [BYTE_AW-1:0] scan_addr_r, scan_addr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  bpa_rsp_t           res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  bpa_rsp_t           out_rsp_r, out_rsp_nxt;

  logic [7:0]         rd_data_r;
  logic               rd_vld_r;
  logic [BYTE_AW-1:0] rd_addr;
  logic [7:0]         cur_byte;

  logic               wr_en;
  logic [BYTE_AW-1:0] wr_addr;
  logic [7:0]         wr_data;

  logic               in_xfer;
  logic [2:0]         free_bit;
  logic               slot_in_range;
  logic               slot_used;
  logic [BYTE_AW-1:0] slot_byte;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  assign cur_byte      = rd_vld_r ? rd_data_r : 8'h00;
  assign slot_in_range = (32'(slot_r) < 32'(NUM_SLOTS));
  assign slot_used     = cur_byte[slot_r[2:0]];
  assign slot_byte     = BYTE_AW'(slot_r >> 3);

  // lowest clear bit of the byte under test
  always_comb begin
    free_bit = 3'd0;
    for (int b = BITS_PER_BYTE - 1; b >= 0; b--) begin
      if (!cur_byte[b]) begin
        free_bit = 3'(b);
      end
    end
  end

  // read address: first byte on request, next byte while scanning
  always_comb begin
    if (state_r == S_SCAN) begin
      rd_addr = scan_addr_r + BYTE_AW'(1);
    end else if (in_req.opcode == OP_ALLOC) begin
      rd_addr = '0;
    end else begin
      rd_addr = BYTE_AW'(in_req.slot_index >> 3);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    slot_nxt      = slot_r;
    scan_addr_nxt = scan_addr_r;
    count_nxt     = count_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_rsp_nxt   = out_rsp_r;
    wr_en         = 1'b0;
    wr_addr       = scan_addr_r;
    wr_data       = cur_byte;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt        = in_req.opcode;
          slot_nxt      = in_req.slot_index;
          scan_addr_nxt = '0;
          res_nxt.success      = 1'b0;
          res_nxt.granted_slot = '0;
          res_nxt.used_count   = 11'(count_r);
          if (in_req.opcode == OP_ALLOC) begin
            state_nxt = S_SCAN;
          end else if (in_req.opcode == OP_FREE || in_req.opcode == OP_QUERY) begin
            state_nxt = S_SLOT;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (cur_byte != FULL_BYTE) begin
          wr_en     = 1'b1;
          wr_addr   = scan_addr_r;
          wr_data   = cur_byte | (8'h01 << free_bit);
          count_nxt = count_r + CNT_W'(1);
          res_nxt.success      = 1'b1;
          res_nxt.granted_slot = 10'({scan_addr_r, free_bit});
          res_nxt.used_count   = 11'(count_r + CNT_W'(1));
          state_nxt = S_DONE;
        end else if (scan_addr_r == BYTE_AW'(NUM_BYTES - 1)) begin
          state_nxt = S_DONE;
        end else begin
          scan_addr_nxt = scan_addr_r + BYTE_AW'(1);
        end
      end
      S_SLOT: begin
        if (op_r == OP_FREE) begin
          if (slot_in_range && slot_used) begin
            wr_en     = 1'b1;
            wr_addr   = slot_byte;
            wr_data   = cur_byte & ~(8'h01 << slot_r[2:0]);
            count_nxt = count_r - CNT_W'(1);
            res_nxt.success    = 1'b1;
            res_nxt.used_count = 11'(count_r - CNT_W'(1));
          end
        end else begin
          res_nxt.success = slot_in_range && !slot_used;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_rsp_nxt   = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    slot_r      <= slot_nxt;
    scan_addr_r <= scan_addr_nxt;
    res_r       <= res_nxt;
    out_rsp_r   <= out_rsp_nxt;
    rd_vld_r    <= byte_vld_r[rd_addr];
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      byte_vld_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        byte_vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      usage_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= usage_mem[rd_addr];
  end

  `BPA_ASSERT_NEXT(a_req_starts_work, in_xfer, state_r != S_IDLE, "request not taken up")
  `BPA_ASSERT(a_count_bound, 32'(count_r) <= 32'(NUM_SLOTS), "slot count out of range")
  `BPA_ASSERT(a_write_in_work, !wr_en || state_r == S_SCAN || state_r == S_SLOT,
              "bitmap written outside a request")
  `BPA_ASSERT(a_grant_needs_success,
              !out_valid_r || out_rsp_r.granted_slot == 10'd0 || out_rsp_r.success,
              "slot granted on failed request")

endmodule

`default_nettype wire
